// ----- design/i2c_master_byte_engine_defines.svh -----
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Clocked property checks shared by the engine RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Check a property at every rising clock edge, suspended while reset is low.
`define I2CMBE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define I2CMBE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Opcodes, bus phase codes and the packed result layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmbe_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_START_A  = 8'b0000_0010,
        PH_START_B  = 8'b0000_0100,
        PH_STOP_A   = 8'b0000_1000,
        PH_STOP_B   = 8'b0001_0000,
        PH_STOP_C   = 8'b0010_0000,
        PH_BIT_LOW  = 8'b0100_0000,
        PH_BIT_HIGH = 8'b1000_0000
    } t_phase;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd9;
    localparam logic [3:0] DATA_BITS         = 4'd8;
    localparam logic [7:0] TICK_MAX          = 8'hFF;

    // Result item, lowest bit first: scl, sda, busy, done, rx_byte, ack, pad.
    typedef struct packed {
        logic [2:0] pad;
        logic       ack_received;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } t_result;

endpackage

// ----- design/i2c_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master: start, stop, write byte and read byte sequences.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: tx, ack, sda; tuser: cmd
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: bus levels, status
//  cfg       in   i_cfg_we                       i_cfg_wdata: phase_ticks
//
//  One tick request is taken per clock; its result is in the output register
//  on the next cycle. The bus state update is one pass of next-state logic.
//  A request is taken whenever the output register is empty or drained in the
//  same cycle, so a stalled master side holds s_axis_tready low.
//  Synchronous active-low reset idles the bus with SCL and SDA released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine
    import i2cmbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] ack_to_send, [9] sda_in
    input  logic [2:0]  s_axis_tuser,   // [0] cmd_valid, [2:1] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] scl, [1] sda, [2] busy, [3] done,
                                        // [11:4] rx_byte, [12] ack_received
);

    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic [7:0] r_phase_ticks;
    t_phase     r_phase,     n_phase;
    logic [3:0] r_bit_index, n_bit_index;
    logic [7:0] r_tick,      n_tick;
    logic [7:0] r_shift,     n_shift;
    t_opcode    r_active_op, n_active_op;
    logic       r_held_ack,  n_held_ack;
    logic       r_scl,       n_scl;
    logic       r_sda,       n_sda;
    logic       r_ack_flag,  n_ack_flag;
    logic [7:0] r_rx_hold,   n_rx_hold;
    logic       n_done;

    logic       s_accept;
    logic       in_cmd_valid;
    t_opcode    in_opcode;
    logic [7:0] in_tx_byte;
    logic       in_ack_to_send;
    logic       in_sda;
    logic [7:0] tick_inc;
    logic       last_data_bit;

    assign in_cmd_valid   = s_axis_tuser[0];
    assign in_opcode      = t_opcode'(s_axis_tuser[2:1]);
    assign in_tx_byte     = s_axis_tdata[7:0];
    assign in_ack_to_send = s_axis_tdata[8];
    assign in_sda         = s_axis_tdata[9];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign tick_inc      = (r_tick == TICK_MAX) ? r_tick : r_tick + 8'd1;
    // the bit that just ended was the eighth data bit or later
    assign last_data_bit = (r_bit_index >= DATA_BITS - 4'd1);

    always_comb begin
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_tick      = r_tick;
        n_shift     = r_shift;
        n_active_op = r_active_op;
        n_held_ack  = r_held_ack;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack_flag  = r_ack_flag;
        n_rx_hold   = r_rx_hold;
        n_done      = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (in_cmd_valid) begin
                n_active_op = in_opcode;
                n_bit_index = 4'd0;
                n_tick      = 8'd0;
                case (in_opcode)
                    OP_START: begin
                        n_phase = PH_START_A;
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                    end
                    OP_STOP: begin
                        n_phase = PH_STOP_A;
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                    end
                    OP_WRITE: begin
                        n_shift    = in_tx_byte;
                        n_held_ack = in_ack_to_send;
                        n_phase    = PH_BIT_LOW;
                        n_scl      = 1'b0;
                        n_sda      = in_tx_byte[7];
                    end
                    default: begin
                        n_shift    = 8'd0;
                        n_held_ack = in_ack_to_send;
                        n_phase    = PH_BIT_LOW;
                        n_scl      = 1'b0;
                        n_sda      = 1'b1;
                    end
                endcase
            end
        end else if (tick_inc < r_phase_ticks) begin
            n_tick = tick_inc;
        end else begin
            // phase ends: enter the next one with a fresh count
            n_tick = 8'd0;
            case (r_phase)
                PH_START_A: begin
                    n_phase = PH_START_B;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                end
                PH_START_B: begin
                    n_phase = PH_IDLE;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                    n_done  = 1'b1;
                end
                PH_STOP_A: begin
                    n_phase = PH_STOP_B;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                end
                PH_STOP_B: begin
                    n_phase = PH_STOP_C;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_STOP_C: begin
                    n_phase = PH_IDLE;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_done  = 1'b1;
                end
                PH_BIT_LOW: begin
                    n_phase = PH_BIT_HIGH;
                    n_scl   = 1'b1;
                end
                PH_BIT_HIGH: begin
                    if (r_bit_index < DATA_BITS) begin
                        n_bit_index = r_bit_index + 4'd1;
                        n_phase     = PH_BIT_LOW;
                        n_scl       = 1'b0;
                        if (r_active_op == OP_WRITE) begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_sda   = last_data_bit ? 1'b1 : r_shift[6];
                        end else begin
                            n_shift = {r_shift[6:0], in_sda};
                            n_sda   = last_data_bit ? r_held_ack : 1'b1;
                        end
                    end else begin
                        n_bit_index = 4'd0;
                        n_phase     = PH_IDLE;
                        n_scl       = 1'b0;
                        n_done      = 1'b1;
                        if (r_active_op == OP_WRITE) begin
                            n_ack_flag = !in_sda;
                        end else begin
                            n_rx_hold = r_shift;
                            n_sda     = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_out.pad          = 3'd0;
        n_out.ack_received = n_ack_flag;
        n_out.rx_byte      = n_rx_hold;
        n_out.done_res     = n_done;
        n_out.busy_res     = (n_phase != PH_IDLE);
        n_out.sda_level    = n_sda;
        n_out.scl_level    = n_scl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
            r_phase       <= PH_IDLE;
            r_bit_index   <= 4'd0;
            r_tick        <= 8'd0;
            r_shift       <= 8'd0;
            r_active_op   <= OP_START;
            r_held_ack    <= 1'b1;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack_flag    <= 1'b0;
            r_rx_hold     <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            if (s_accept) begin
                r_phase     <= n_phase;
                r_bit_index <= n_bit_index;
                r_tick      <= n_tick;
                r_shift     <= n_shift;
                r_active_op <= n_active_op;
                r_held_ack  <= n_held_ack;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_ack_flag  <= n_ack_flag;
                r_rx_hold   <= n_rx_hold;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result register while the master side stalls
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= n_out;
        end
    end

    `I2CMBE_ASSERT(a_cmd_leaves_idle, i_clk, i_rst_n, s_accept && (r_phase == PH_IDLE) && in_cmd_valid |=> r_phase != PH_IDLE, "accepted command did not leave idle")
    `I2CMBE_ASSERT(a_done_goes_idle, i_clk, i_rst_n, s_accept && n_done |=> r_phase == PH_IDLE && m_axis_tdata[3] && !m_axis_tdata[2], "done reported without returning to idle")
    `I2CMBE_ASSERT(a_bit_phase_op, i_clk, i_rst_n, (r_phase == PH_BIT_LOW || r_phase == PH_BIT_HIGH) |-> (r_active_op == OP_WRITE || r_active_op == OP_READ), "bit phase outside a byte command")
    `I2CMBE_ASSERT(a_bit_index_range, i_clk, i_rst_n, r_bit_index <= DATA_BITS, "bit index past the ack clock")
    `I2CMBE_ASSERT_ALWAYS(a_stall_blocks_input, i_clk, r_out_valid && !m_axis_tready |-> !s_axis_tready, "request taken while result stalled")

endmodule
